### hdl/gap_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gap_pkg
// Shared types and constants for the grid path search core: grid geometry,
// request and response codes, cell marks, directions and the micro-ops that
// the controller issues to the datapath.
// ---------------------------------------------------------------------------
package gap_pkg;

  localparam int CoordW = 6;
  localparam int IdxW   = 2 * CoordW;
  localparam int Ncells = 1 << IdxW;
  localparam int CntW   = IdxW + 1;
  localparam int GW     = IdxW;
  localparam int HW     = CoordW + 1;
  localparam int BitcW  = 3;

  localparam logic [CoordW-1:0] CoordMax = '1;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_SOLVE = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  localparam logic [1:0] CFG_START_X = 2'd0;
  localparam logic [1:0] CFG_START_Y = 2'd1;
  localparam logic [1:0] CFG_END_X   = 2'd2;
  localparam logic [1:0] CFG_END_Y   = 2'd3;

  localparam logic RESP_STATUS = 1'b0;
  localparam logic RESP_STEP   = 1'b1;

  localparam logic [1:0] MARK_UNSEEN = 2'd0;
  localparam logic [1:0] MARK_OPEN   = 2'd1;
  localparam logic [1:0] MARK_CLOSED = 2'd2;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  typedef struct packed {
    logic [GW-1:0] g;
    logic [HW-1:0] h;
    logic [1:0]    d;
  } info_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_WCLR,
    OP_MCLR,
    OP_START,
    OP_H_LOAD,
    OP_H_STEP,
    OP_OPEN,
    OP_LOOP,
    OP_SCAN_A,
    OP_SCAN_B,
    OP_SCAN_C,
    OP_RM_INIT,
    OP_RM_A,
    OP_RM_B,
    OP_RM_END,
    OP_NB_RD,
    OP_NB_NEXT,
    OP_TR_A,
    OP_TR_B,
    OP_RES_STATUS,
    OP_RES_STEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   accept;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic count_zero;
    logic scan_last;
    logic rm_more;
    logic is_goal;
    logic nb_in;
    logic nb_free;
    logic dir_last;
    logic h_done;
    logic tr_stop;
    logic tr_zero;
  } dp_stat_t;

endpackage
`default_nettype wire

### hdl/grid_astar_path_search_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// grid_astar_path_search_core
// 4-connected A* search over a 64x64 wall map with an insertion-ordered
// open list; map writes, search requests and path step reads.
// ---------------------------------------------------------------------------
// Map write: accepted with no response. Step read: one response per request
// transaction; the next request is taken once that response is loaded.
// Search: mark clearing of all 4096 cells, then per round a scan of the
// open entries, compaction of the entries behind the pick and a square
// root per opened neighbor, then a trace of the path steps.
// After reset the wall map is cleared with in_ready low;
// configuration writes are taken at any time.
// ---------------------------------------------------------------------------
module grid_astar_path_search_core
  import gap_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CoordW-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        req_type,
  input  wire logic [CoordW-1:0] cell_x,
  input  wire logic [CoordW-1:0] cell_y,
  input  wire logic              wall,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   resp_kind,
  output logic                   found,
  output logic [GW-1:0]          path_length,
  output logic                   step_valid,
  output logic [1:0]             step_dir,
  output logic                   turn,
  output logic                   last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  gap_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  gap_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_type    (req_type),
    .cell_x      (cell_x),
    .cell_y      (cell_y),
    .wall        (wall),
    .cmd         (cmd),
    .stat        (stat),
    .resp_kind   (resp_kind),
    .found       (found),
    .path_length (path_length),
    .step_valid  (step_valid),
    .step_dir    (step_dir),
    .turn        (turn),
    .last        (last)
  );

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && resp_kind == RESP_STATUS |->
      !step_valid && !turn && !last && step_dir == DIR_UP)
    else $error("status transaction carries step fields");

  a_step_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && resp_kind == RESP_STEP |-> !found && path_length == '0)
    else $error("step transaction carries search fields");

  a_no_path_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && resp_kind == RESP_STATUS && !found |-> path_length == '0)
    else $error("failed search reports a path length");

  a_empty_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && resp_kind == RESP_STEP && !step_valid |->
      !last && !turn && step_dir == DIR_UP)
    else $error("empty step read carries step data");

endmodule
`default_nettype wire

### hdl/gap_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gap_dp
// Datapath of the grid path search core: configuration registers, cell
// memories, open list, heuristic square root unit, path store and the
// result registers. Executes one micro-op per cycle.
// ---------------------------------------------------------------------------
module gap_dp
  import gap_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CoordW-1:0] cfg_data,
  input  wire logic [1:0]        req_type,
  input  wire logic [CoordW-1:0] cell_x,
  input  wire logic [CoordW-1:0] cell_y,
  input  wire logic              wall,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               stat,
  output logic                   resp_kind,
  output logic                   found,
  output logic [GW-1:0]          path_length,
  output logic                   step_valid,
  output logic [1:0]             step_dir,
  output logic                   turn,
  output logic                   last
);

  logic              wall_mem  [Ncells];
  logic [1:0]        mark_mem  [Ncells];
  info_t             info_mem  [Ncells];
  logic [IdxW-1:0]   order_mem [Ncells];
  logic [1:0]        path_mem  [Ncells];

  logic [CoordW-1:0] start_x, start_y, end_x, end_y;
  logic [CntW-1:0]   i, count, pick_pos;
  logic [GW-1:0]     step_cnt, rp, pick_g, cand_g;
  logic [1:0]        prev_dir, dir, cand_d;
  logic              goal_hit;
  logic [CntW-1:0]   pick_f;
  logic [HW-1:0]     pick_h, root;
  logic [IdxW-1:0]   pick_idx, e_idx, cur;
  logic [CoordW-1:0] cand_x, cand_y;
  logic [CntW-1:0]   hv;
  logic [BitcW-1:0]  bitc;

  logic              rd_wall;
  logic [1:0]        rd_mark;
  info_t             rd_info;
  logic [IdxW-1:0]   rd_order;
  logic [1:0]        rd_path;

  logic              wall_we, wall_wd;
  logic [IdxW-1:0]   wall_wa;
  logic              mark_we;
  logic [1:0]        mark_wd;
  logic [IdxW-1:0]   mark_wa;
  logic              info_we;
  logic [IdxW-1:0]   info_ra;
  logic              order_we;
  logic [IdxW-1:0]   order_wa, order_wd, order_ra;
  logic              path_we;
  logic [IdxW-1:0]   path_wa;

  logic [CoordW-1:0] px, py, nb_x, nb_y, cx, cy, tx, ty;
  logic              nb_in, tr_oob;
  logic [IdxW-1:0]   nb_idx, cand_idx, goal_idx;
  logic [CntW-1:0]   i_inc, i_dec, f_a;
  logic signed [HW-1:0]   hdx, hdy;
  logic signed [2*HW-1:0] hsqx, hsqy;
  logic [HW-1:0]     trial;
  logic [2*HW-1:0]   trial_sq;
  logic              room;

  assign px       = pick_idx[CoordW-1:0];
  assign py       = pick_idx[IdxW-1:CoordW];
  assign cx       = cur[CoordW-1:0];
  assign cy       = cur[IdxW-1:CoordW];
  assign nb_idx   = {nb_y, nb_x};
  assign cand_idx = {cand_y, cand_x};
  assign goal_idx = {end_y, end_x};
  assign i_inc    = i + CntW'(1);
  assign i_dec    = i - CntW'(1);
  assign f_a      = {1'b0, rd_info.g} + CntW'(rd_info.h);
  assign hdx      = signed'({1'b0, end_x}) - signed'({1'b0, cand_x});
  assign hdy      = signed'({1'b0, end_y}) - signed'({1'b0, cand_y});
  assign hsqx     = hdx * hdx;
  assign hsqy     = hdy * hdy;
  assign trial    = root | (HW'(1) << bitc);
  assign trial_sq = trial * trial;
  assign room     = !count[CntW-1];

  always_comb begin
    case (dir)
      DIR_UP: begin
        nb_x = px; nb_y = py + CoordW'(1); nb_in = (py != CoordMax);
      end
      DIR_RIGHT: begin
        nb_x = px + CoordW'(1); nb_y = py; nb_in = (px != CoordMax);
      end
      DIR_DOWN: begin
        nb_x = px; nb_y = py - CoordW'(1); nb_in = (py != '0);
      end
      DIR_LEFT: begin
        nb_x = px - CoordW'(1); nb_y = py; nb_in = (px != '0);
      end
    endcase
  end

  always_comb begin
    case (rd_info.d)
      DIR_UP: begin
        tx = cx; ty = cy - CoordW'(1); tr_oob = (cy == '0);
      end
      DIR_RIGHT: begin
        tx = cx - CoordW'(1); ty = cy; tr_oob = (cx == '0);
      end
      DIR_DOWN: begin
        tx = cx; ty = cy + CoordW'(1); tr_oob = (cy == CoordMax);
      end
      DIR_LEFT: begin
        tx = cx + CoordW'(1); ty = cy; tr_oob = (cx == CoordMax);
      end
    endcase
  end

  always_comb begin
    stat.cnt_last   = &i[IdxW-1:0];
    stat.count_zero = (count == '0);
    stat.scan_last  = (i == count - CntW'(1));
    stat.rm_more    = (i_inc < count);
    stat.is_goal    = (pick_idx == goal_idx);
    stat.nb_in      = nb_in;
    stat.nb_free    = !rd_wall && (rd_mark == MARK_UNSEEN);
    stat.dir_last   = (dir == DIR_LEFT);
    stat.h_done     = (bitc == '0);
    stat.tr_stop    = (i == CntW'(1)) || tr_oob;
    stat.tr_zero    = (pick_g == '0);
  end

  always_comb begin
    wall_we  = 1'b0;
    wall_wa  = i[IdxW-1:0];
    wall_wd  = 1'b0;
    mark_we  = 1'b0;
    mark_wa  = i[IdxW-1:0];
    mark_wd  = MARK_UNSEEN;
    info_we  = 1'b0;
    info_ra  = cur;
    order_we = 1'b0;
    order_wa = i[IdxW-1:0];
    order_wd = rd_order;
    order_ra = i[IdxW-1:0];
    path_we  = 1'b0;
    path_wa  = i_dec[IdxW-1:0];
    unique case (cmd.op)
      OP_NOP: begin
        if (cmd.accept && req_type == REQ_WRITE) begin
          wall_we = 1'b1;
          wall_wa = {cell_y, cell_x};
          wall_wd = wall;
        end
      end
      OP_WCLR: wall_we = 1'b1;
      OP_MCLR: mark_we = 1'b1;
      OP_OPEN: begin
        if (room) begin
          mark_we  = 1'b1;
          mark_wa  = cand_idx;
          mark_wd  = MARK_OPEN;
          info_we  = 1'b1;
          order_we = 1'b1;
          order_wa = count[IdxW-1:0];
          order_wd = cand_idx;
        end
      end
      OP_SCAN_B: info_ra = rd_order;
      OP_RM_A:   order_ra = i_inc[IdxW-1:0];
      OP_RM_B:   order_we = 1'b1;
      OP_RM_END: begin
        mark_we = 1'b1;
        mark_wa = pick_idx;
        mark_wd = MARK_CLOSED;
      end
      OP_TR_B:   path_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wall_we) wall_mem[wall_wa] <= wall_wd;
    rd_wall <= wall_mem[nb_idx];
  end

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    rd_mark <= mark_mem[nb_idx];
  end

  always_ff @(posedge clk) begin
    if (info_we) info_mem[cand_idx] <= '{g: cand_g, h: root, d: cand_d};
    rd_info <= info_mem[info_ra];
  end

  always_ff @(posedge clk) begin
    if (order_we) order_mem[order_wa] <= order_wd;
    rd_order <= order_mem[order_ra];
  end

  always_ff @(posedge clk) begin
    if (path_we) path_mem[path_wa] <= rd_info.d;
    rd_path <= path_mem[rp];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x  <= '0;
      start_y  <= '0;
      end_x    <= '0;
      end_y    <= '0;
      i        <= '0;
      count    <= '0;
      step_cnt <= '0;
      rp       <= '0;
      prev_dir <= DIR_UP;
      goal_hit <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_START_X: start_x <= cfg_data;
          CFG_START_Y: start_y <= cfg_data;
          CFG_END_X:   end_x   <= cfg_data;
          CFG_END_Y:   end_y   <= cfg_data;
        endcase
      end
      unique case (cmd.op)
        OP_NOP: begin
          if (cmd.accept && req_type == REQ_SOLVE) begin
            i        <= '0;
            count    <= '0;
            step_cnt <= '0;
            rp       <= '0;
            prev_dir <= DIR_UP;
            goal_hit <= 1'b0;
          end
        end
        OP_WCLR, OP_MCLR: i <= stat.cnt_last ? '0 : i_inc;
        OP_START: begin
          cand_x <= start_x;
          cand_y <= start_y;
          cand_g <= '0;
          cand_d <= DIR_UP;
        end
        OP_H_LOAD: begin
          hv   <= CntW'(unsigned'(hsqx)) + CntW'(unsigned'(hsqy));
          root <= '0;
          bitc <= BitcW'(HW - 1);
        end
        OP_H_STEP: begin
          if (trial_sq <= (2*HW)'(hv)) root <= trial;
          bitc <= bitc - BitcW'(1);
        end
        OP_OPEN:  if (room) count <= count + CntW'(1);
        OP_LOOP:  i <= '0;
        OP_SCAN_B: e_idx <= rd_order;
        OP_SCAN_C: begin
          if (i == '0 || (f_a <= pick_f && rd_info.h < pick_h)) begin
            pick_pos <= i;
            pick_f   <= f_a;
            pick_h   <= rd_info.h;
            pick_idx <= e_idx;
            pick_g   <= rd_info.g;
          end
          i <= i_inc;
        end
        OP_RM_INIT: i <= pick_pos;
        OP_RM_B:    i <= i_inc;
        OP_RM_END: begin
          count <= count - CntW'(1);
          dir   <= DIR_UP;
          if (stat.is_goal) begin
            goal_hit <= 1'b1;
            step_cnt <= pick_g;
            i        <= CntW'(pick_g);
            cur      <= pick_idx;
          end
        end
        OP_NB_RD: begin
          cand_x <= nb_x;
          cand_y <= nb_y;
          cand_g <= pick_g + GW'(1);
          cand_d <= dir;
        end
        OP_NB_NEXT: dir <= dir + 2'd1;
        OP_TR_B: begin
          i   <= i_dec;
          cur <= {ty, tx};
        end
        OP_RES_STATUS: begin
          resp_kind   <= RESP_STATUS;
          found       <= goal_hit;
          path_length <= goal_hit ? step_cnt : '0;
          step_valid  <= 1'b0;
          step_dir    <= DIR_UP;
          turn        <= 1'b0;
          last        <= 1'b0;
        end
        OP_RES_STEP: begin
          resp_kind   <= RESP_STEP;
          found       <= 1'b0;
          path_length <= '0;
          if (rp < step_cnt) begin
            step_valid <= 1'b1;
            step_dir   <= rd_path;
            turn       <= (rd_path != prev_dir);
            last       <= ({1'b0, rp} + CntW'(1) == {1'b0, step_cnt});
            prev_dir   <= rd_path;
            rp         <= rp + GW'(1);
          end else begin
            step_valid <= 1'b0;
            step_dir   <= DIR_UP;
            turn       <= 1'b0;
            last       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/gap_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gap_ctrl
// Controller of the grid path search core: sequences map clearing, search
// rounds, open list scan and compaction, neighbor expansion, path trace
// and result hand-off, and owns the request and response handshakes.
// ---------------------------------------------------------------------------
module gap_ctrl
  import gap_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] req_type,
  output logic            out_valid,
  input  wire logic       out_ready,
  output dp_cmd_t         cmd,
  input  wire dp_stat_t   stat
);

  typedef enum logic [4:0] {
    S_WCLR, S_IDLE, S_MCLR, S_START, S_HLOAD, S_HSTEP, S_OPEN, S_LOOP,
    S_SCAN_A, S_SCAN_B, S_SCAN_C, S_RM_INIT, S_RM_CHK, S_RM_A, S_RM_B,
    S_RM_END, S_NB_CHK, S_NB_B, S_NB_NEXT, S_TR_A, S_TR_B, S_RES, S_RD
  } state_t;

  state_t state, state_next;
  logic   from_nb, from_nb_next;
  logic   out_free, out_load;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    from_nb_next = from_nb;
    out_load     = 1'b0;
    cmd.op       = OP_NOP;
    cmd.accept   = 1'b0;
    unique case (state)
      S_WCLR: begin
        cmd.op = OP_WCLR;
        if (stat.cnt_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          case (req_type)
            REQ_SOLVE: state_next = S_MCLR;
            REQ_READ:  state_next = S_RD;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_MCLR: begin
        cmd.op = OP_MCLR;
        if (stat.cnt_last) state_next = S_START;
      end
      S_START: begin
        cmd.op       = OP_START;
        from_nb_next = 1'b0;
        state_next   = S_HLOAD;
      end
      S_HLOAD: begin
        cmd.op     = OP_H_LOAD;
        state_next = S_HSTEP;
      end
      S_HSTEP: begin
        cmd.op = OP_H_STEP;
        if (stat.h_done) state_next = S_OPEN;
      end
      S_OPEN: begin
        cmd.op     = OP_OPEN;
        state_next = from_nb ? S_NB_NEXT : S_LOOP;
      end
      S_LOOP: begin
        cmd.op     = OP_LOOP;
        state_next = stat.count_zero ? S_RES : S_SCAN_A;
      end
      S_SCAN_A: begin
        cmd.op     = OP_SCAN_A;
        state_next = S_SCAN_B;
      end
      S_SCAN_B: begin
        cmd.op     = OP_SCAN_B;
        state_next = S_SCAN_C;
      end
      S_SCAN_C: begin
        cmd.op     = OP_SCAN_C;
        state_next = stat.scan_last ? S_RM_INIT : S_SCAN_A;
      end
      S_RM_INIT: begin
        cmd.op     = OP_RM_INIT;
        state_next = S_RM_CHK;
      end
      S_RM_CHK: state_next = stat.rm_more ? S_RM_A : S_RM_END;
      S_RM_A: begin
        cmd.op     = OP_RM_A;
        state_next = S_RM_B;
      end
      S_RM_B: begin
        cmd.op     = OP_RM_B;
        state_next = S_RM_CHK;
      end
      S_RM_END: begin
        cmd.op = OP_RM_END;
        if (stat.is_goal) state_next = stat.tr_zero ? S_RES : S_TR_A;
        else state_next = S_NB_CHK;
      end
      S_NB_CHK: begin
        cmd.op       = OP_NB_RD;
        from_nb_next = 1'b1;
        state_next   = stat.nb_in ? S_NB_B : S_NB_NEXT;
      end
      S_NB_B: state_next = stat.nb_free ? S_HLOAD : S_NB_NEXT;
      S_NB_NEXT: begin
        cmd.op     = OP_NB_NEXT;
        state_next = stat.dir_last ? S_LOOP : S_NB_CHK;
      end
      S_TR_A: begin
        cmd.op     = OP_TR_A;
        state_next = S_TR_B;
      end
      S_TR_B: begin
        cmd.op     = OP_TR_B;
        state_next = stat.tr_stop ? S_RES : S_TR_A;
      end
      S_RES: begin
        if (out_free) begin
          cmd.op     = OP_RES_STATUS;
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RD: begin
        if (out_free) begin
          cmd.op     = OP_RES_STEP;
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_WCLR;
      from_nb   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      from_nb   <= from_nb_next;
      out_valid <= out_load || (out_valid && !out_ready);
    end
  end

endmodule
`default_nettype wire

### dv/tb_grid_astar_path_search_core.sv
// ---------------------------------------------------------------------------
// tb_grid_astar_path_search_core
// Self-checking bench for the grid path search core. A behavioral A* model
// predicts each search status and path step. Map writes, searches and step
// reads are driven over valid/ready with random gaps and output stalls.
// ---------------------------------------------------------------------------
module tb_grid_astar_path_search_core;
  import gap_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GridN = 64;
  localparam longint CycleLimit = 64'd200_000_000;

  typedef struct {
    logic        kind;
    logic        fnd;
    logic [11:0] plen;
    logic        sv;
    logic [1:0]  dir;
    logic        trn;
    logic        lst;
  } resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [CoordW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] req_type = '0;
  logic [CoordW-1:0] cell_x = '0;
  logic [CoordW-1:0] cell_y = '0;
  logic wall = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic resp_kind, found, step_valid, turn, last;
  logic [GW-1:0] path_length;
  logic [1:0] step_dir;

  grid_astar_path_search_core uut (.*);

  always #1 clk = ~clk;

  bit          walls [Ncells];
  logic [1:0]  mark [Ncells];
  int          cost [Ncells];
  int          heur [Ncells];
  logic [1:0]  from [Ncells];
  int          olist [$];
  logic [1:0]  steps [Ncells];
  int          nsteps, rdptr;
  logic [1:0]  prevdir;
  int          sx, sy, ex, ey;
  resp_t       pending [$];
  int          errors = 0;
  longint      cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int int_sqrt(int v);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic int goal_dist(int x, int y);
    return int_sqrt((ex - x) * (ex - x) + (ey - y) * (ey - y));
  endfunction

  function automatic void open_node(int x, int y, int g, logic [1:0] d);
    int i;
    i = y * GridN + x;
    mark[i] = MARK_OPEN;
    cost[i] = g;
    heur[i] = goal_dist(x, y);
    from[i] = d;
    olist.push_back(i);
  endfunction

  function automatic bit search_path();
    int goal, pick, node, x, y, nx, ny, cur, k;
    logic [1:0] d;
    nsteps = 0;
    rdptr = 0;
    prevdir = DIR_UP;
    olist.delete();
    foreach (mark[i]) mark[i] = MARK_UNSEEN;
    goal = ey * GridN + ex;
    open_node(sx, sy, 0, DIR_UP);
    while (olist.size() > 0) begin
      pick = 0;
      for (int i = 1; i < olist.size(); i++)
        if (cost[olist[i]] + heur[olist[i]] <= cost[olist[pick]] + heur[olist[pick]] &&
            heur[olist[i]] < heur[olist[pick]])
          pick = i;
      node = olist[pick];
      olist.delete(pick);
      mark[node] = MARK_CLOSED;
      if (node == goal) break;
      nx = node % GridN;
      ny = node / GridN;
      for (int j = 0; j < 4; j++) begin
        d = j[1:0];
        x = nx + (d == DIR_RIGHT) - (d == DIR_LEFT);
        y = ny + (d == DIR_UP) - (d == DIR_DOWN);
        if (x < 0 || x >= GridN || y < 0 || y >= GridN) continue;
        if (walls[y * GridN + x] || mark[y * GridN + x] != MARK_UNSEEN) continue;
        open_node(x, y, cost[node] + 1, d);
      end
    end
    if (mark[goal] != MARK_CLOSED) return 1'b0;
    nsteps = cost[goal];
    cur = goal;
    for (k = nsteps; k > 0; k--) begin
      d = from[cur];
      steps[k - 1] = d;
      x = cur % GridN - ((d == DIR_RIGHT) - (d == DIR_LEFT));
      y = cur / GridN - ((d == DIR_UP) - (d == DIR_DOWN));
      cur = y * GridN + x;
    end
    return 1'b1;
  endfunction

  function automatic void predict(logic [1:0] rq, int x, int y, bit w);
    resp_t r;
    r = '{default: '0};
    case (rq)
      REQ_WRITE: walls[y * GridN + x] = w;
      REQ_SOLVE: begin
        r.kind = RESP_STATUS;
        r.fnd = search_path();
        r.plen = r.fnd ? nsteps[11:0] : 12'd0;
        pending.push_back(r);
      end
      REQ_READ: begin
        r.kind = RESP_STEP;
        if (rdptr < nsteps) begin
          r.sv = 1'b1;
          r.dir = steps[rdptr];
          r.trn = r.dir != prevdir;
          r.lst = rdptr + 1 == nsteps;
          prevdir = r.dir;
          rdptr++;
        end
        pending.push_back(r);
      end
      default: ;
    endcase
  endfunction

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (n > 0) in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_req(logic [1:0] rq, int x, int y, bit w, bit gaps = 1);
    if (gaps) idle_gap();
    in_valid <= 1'b1;
    req_type <= rq;
    cell_x <= x[5:0];
    cell_y <= y[5:0];
    wall <= w;
    do @(posedge clk); while (!in_ready);
    predict(rq, x, y, w);
  endtask

  task automatic write_reg(logic [1:0] idx, int v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[5:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_START_X: sx = v;
      CFG_START_Y: sy = v;
      CFG_END_X:   ex = v;
      default:     ey = v;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_route(int a, int b, int c, int d);
    drain();
    write_reg(CFG_START_X, a);
    write_reg(CFG_START_Y, b);
    write_reg(CFG_END_X, c);
    write_reg(CFG_END_Y, d);
    cfg_valid <= 1'b0;
  endtask

  task automatic read_all(int n);
    repeat (n) send_req(REQ_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                        1'($urandom_range(0, 1)));
  endtask

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
  end

  always @(posedge clk) begin
    resp_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        $display("%0t unexpected result kind=%0d", $time, resp_kind);
        errors++;
      end else begin
        e = pending.pop_front();
        if ({resp_kind, found, path_length, step_valid, step_dir, turn, last} !==
            {e.kind, e.fnd, e.plen, e.sv, e.dir, e.trn, e.lst}) begin
          $display("%0t mismatch exp kind=%0d found=%0d len=%0d sv=%0d dir=%0d turn=%0d last=%0d",
                   $time, e.kind, e.fnd, e.plen, e.sv, e.dir, e.trn, e.lst);
          $display("%0t          act kind=%0d found=%0d len=%0d sv=%0d dir=%0d turn=%0d last=%0d",
                   $time, resp_kind, found, path_length, step_valid, step_dir, turn, last);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_req(REQ_READ, 0, 0, 0);
    send_req(REQ_SOLVE, 0, 0, 0);
    read_all(1);
    set_route(0, 0, 3, 2);
    send_req(REQ_WRITE, 63, 63, 1);
    send_req(REQ_WRITE, 1, 0, 1);
    send_req(REQ_WRITE, 0, 0, 1);
    send_req(REQ_WRITE, 63, 63, 0);
    send_req(2'd3, 63, 63, 1);
    send_req(REQ_SOLVE, 0, 0, 0);
    read_all(7);
    set_route(5, 5, 5, 5);
    send_req(REQ_SOLVE, 0, 0, 0);
    read_all(1);
    set_route(63, 63, 60, 63);
    send_req(REQ_SOLVE, 0, 0, 0);
    read_all(4);
    send_req(REQ_WRITE, 60, 63, 1);
    send_req(REQ_SOLVE, 0, 0, 0);
    send_req(REQ_WRITE, 60, 63, 0);
  endtask

  task automatic test_box_fail();
    set_route(10, 10, 1, 1);
    send_req(REQ_WRITE, 1, 2, 1);
    send_req(REQ_WRITE, 2, 1, 1);
    send_req(REQ_WRITE, 0, 1, 1);
    send_req(REQ_WRITE, 1, 0, 1);
    send_req(REQ_SOLVE, 0, 0, 0);
    read_all(1);
    foreach (walls[i]) if (walls[i]) send_req(REQ_WRITE, i % GridN, i / GridN, 0, 0);
  endtask

  task automatic test_random();
    int x0, y0, n;
    for (int r = 0; r < 5; r++) begin
      x0 = $urandom_range(0, 56);
      y0 = $urandom_range(0, 56);
      set_route(x0 + $urandom_range(0, 7), y0 + $urandom_range(0, 7),
                x0 + $urandom_range(0, 7), y0 + $urandom_range(0, 7));
      n = $urandom_range(2, 8);
      repeat (n) send_req(REQ_WRITE, x0 + $urandom_range(0, 7), y0 + $urandom_range(0, 7),
                          1'($urandom_range(0, 1)));
      send_req(2'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 63),
               1'($urandom_range(0, 1)));
      send_req(REQ_SOLVE, 0, 0, 0);
      read_all($urandom_range(0, 6) + nsteps);
      if (r == 2) drain();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    sx = 0; sy = 0; ex = 0; ey = 0;
    foreach (walls[i]) walls[i] = 1'b0;
    test_directed();
    test_box_fail();
    test_random();
    drain();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
